>>> hdl/assert_macros.svh
// Assertion macros for the checker module of the I2C byte engine.
// Depends on nothing; each macro expands to one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hdl/i2cm_pkg.sv
// Package for the I2C master byte engine: request codes, phase encoding,
// engine state and per-tick result types. No dependencies.
package i2cm_pkg;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;

  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

  // Step positions within the head and tail sequences
  localparam logic [COUNT_W-1:0] STEP_0 = 3'd0;
  localparam logic [COUNT_W-1:0] STEP_1 = 3'd1;
  localparam logic [COUNT_W-1:0] STEP_2 = 3'd2;
  localparam logic [COUNT_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HEAD  = 8'b0000_0010,
    PH_WLOW  = 8'b0000_0100,
    PH_WDATA = 8'b0000_1000,
    PH_WHIGH = 8'b0001_0000,
    PH_RHIGH = 8'b0010_0000,
    PH_RLOW  = 8'b0100_0000,
    PH_TAIL  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [REQ_W-1:0]    operation;
    logic [COUNT_W-1:0]  bit_count;
    logic [BYTE_W-1:0]   shift_reg;
    logic                ack_request;
    logic                scl;
    logic                sda;
    logic [BYTE_W-1:0]   rx_hold;
    logic                ack_hold;
  } eng_state_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_status;
  } tick_res_t;

  localparam eng_state_t STATE_RST = '{
    phase:       PH_IDLE,
    operation:   REQ_TICK,
    bit_count:   '0,
    shift_reg:   '0,
    ack_request: 1'b0,
    scl:         1'b1,
    sda:         1'b1,
    rx_hold:     '0,
    ack_hold:    1'b0
  };

endpackage

>>> hdl/i2cm_step.sv
// Next-state logic of the I2C master byte engine: one pin operation per tick.
// Depends on i2cm_pkg for codes, phases and the state and result structs.
module i2cm_step (
  input  i2cm_pkg::eng_state_t           state_i,
  input  logic [i2cm_pkg::REQ_W-1:0]     req_type,
  input  logic [i2cm_pkg::BYTE_W-1:0]    tx_byte,
  input  logic                           send_ack,
  input  logic                           sda_sample,
  output i2cm_pkg::eng_state_t           state_o,
  output i2cm_pkg::tick_res_t            res_o
);

  i2cm_pkg::eng_state_t         s;
  logic [i2cm_pkg::COUNT_W-1:0] idx;
  logic                         busy;
  logic                         fin;

  always_comb begin
    s    = state_i;
    busy = 1'b0;
    fin  = 1'b0;
    idx  = '0;

    // Take a command only while idle
    if (s.phase == i2cm_pkg::PH_IDLE && req_type >= i2cm_pkg::REQ_START &&
        req_type <= i2cm_pkg::REQ_READ) begin
      s.operation   = req_type;
      s.bit_count   = '0;
      s.ack_request = send_ack;
      if (req_type == i2cm_pkg::REQ_WRITE) begin
        s.shift_reg = tx_byte;
        s.phase     = i2cm_pkg::PH_WLOW;
      end else begin
        s.shift_reg = '0;
        s.phase     = i2cm_pkg::PH_HEAD;
      end
    end

    if (s.phase != i2cm_pkg::PH_IDLE) begin
      busy = 1'b1;
      idx  = s.bit_count;
      unique case (s.phase)
        i2cm_pkg::PH_HEAD: begin
          s.bit_count = idx + 3'd1;
          if (s.operation == i2cm_pkg::REQ_START) begin
            priority if (idx == i2cm_pkg::STEP_0) s.scl = 1'b1;
            else if (idx == i2cm_pkg::STEP_1)     s.sda = 1'b1;
            else if (idx == i2cm_pkg::STEP_2)     s.sda = 1'b0;
            else begin
              s.scl = 1'b0;
              fin   = 1'b1;
            end
          end else if (s.operation == i2cm_pkg::REQ_STOP) begin
            priority if (idx == i2cm_pkg::STEP_0) s.scl = 1'b0;
            else if (idx == i2cm_pkg::STEP_1)     s.sda = 1'b0;
            else if (idx == i2cm_pkg::STEP_2)     s.scl = 1'b1;
            else begin
              s.sda = 1'b1;
              fin   = 1'b1;
            end
          end else begin
            // Read preamble: drop SCL, release SDA, then enter the bit loop
            if (idx == i2cm_pkg::STEP_0) begin
              s.scl = 1'b0;
            end else begin
              s.sda       = 1'b1;
              s.phase     = i2cm_pkg::PH_RHIGH;
              s.bit_count = '0;
            end
          end
        end
        i2cm_pkg::PH_WLOW: begin
          s.scl   = 1'b0;
          s.phase = i2cm_pkg::PH_WDATA;
        end
        i2cm_pkg::PH_WDATA: begin
          s.sda       = |(s.shift_reg & i2cm_pkg::MSB_MASK);
          s.shift_reg = {s.shift_reg[i2cm_pkg::BYTE_W-2:0], 1'b0};
          s.phase     = i2cm_pkg::PH_WHIGH;
        end
        i2cm_pkg::PH_WHIGH: begin
          s.scl = 1'b1;
          if (idx == i2cm_pkg::LAST_BIT) begin
            s.phase     = i2cm_pkg::PH_TAIL;
            s.bit_count = '0;
          end else begin
            s.phase     = i2cm_pkg::PH_WLOW;
            s.bit_count = idx + 3'd1;
          end
        end
        i2cm_pkg::PH_RHIGH: begin
          s.scl       = 1'b1;
          s.shift_reg = {s.shift_reg[i2cm_pkg::BYTE_W-2:0], sda_sample};
          s.phase     = i2cm_pkg::PH_RLOW;
        end
        i2cm_pkg::PH_RLOW: begin
          s.scl = 1'b0;
          if (idx == i2cm_pkg::LAST_BIT) begin
            s.phase     = i2cm_pkg::PH_TAIL;
            s.bit_count = '0;
          end else begin
            s.phase     = i2cm_pkg::PH_RHIGH;
            s.bit_count = idx + 3'd1;
          end
        end
        i2cm_pkg::PH_TAIL: begin
          s.bit_count = idx + 3'd1;
          if (s.operation == i2cm_pkg::REQ_WRITE) begin
            priority if (idx == i2cm_pkg::STEP_0) s.scl = 1'b0;
            else if (idx == i2cm_pkg::STEP_1)     s.sda = 1'b1;
            else if (idx == i2cm_pkg::STEP_2) begin
              // Sample the slave ACK while SCL is high
              s.scl      = 1'b1;
              s.ack_hold = sda_sample;
            end else begin
              s.scl = 1'b0;
              fin   = 1'b1;
            end
          end else begin
            priority if (idx == i2cm_pkg::STEP_0) begin
              if (s.ack_request) s.sda = 1'b0;
            end else if (idx == i2cm_pkg::STEP_1) begin
              s.scl = 1'b1;
            end else begin
              s.scl     = 1'b0;
              s.rx_hold = s.shift_reg;
              fin       = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      s.phase     = i2cm_pkg::PH_IDLE;
      s.bit_count = '0;
    end
  end

  assign state_o          = s;
  assign res_o.scl_level  = s.scl;
  assign res_o.sda_level  = s.sda;
  assign res_o.busy_res   = busy;
  assign res_o.done_res   = fin;
  assign res_o.rx_byte    = s.rx_hold;
  assign res_o.ack_status = s.ack_hold;

endmodule

>>> hdl/i2c_master_byte_engine_unit.sv
// Top level of the I2C master byte engine: stream handshake, state and result registers.
// Depends on i2cm_pkg and i2cm_step.
//
//   channel  dir  tdata (low bit first)                         tuser      tlast
//   in_      in   tx_byte[7:0] send_ack[8] sda_sample[9] 0-pad  req_type   -
//   out_     out  scl[0] sda[1] busy[2] rx_byte[10:3] ack[11]   -          done_res
//
// One tick per cycle unless stalled: each accepted transaction updates the engine state and
// loads the result register in the same cycle; the step logic is the only path between them.
// A new transaction is taken while the previous result is being taken.
// Reset (rst_n low, synchronous) releases SCL and SDA and returns the engine to idle.
// A stalled result holds and in_tready falls until it is taken.
module i2c_master_byte_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], send_ack[8], sda_sample[9], zero [15:10]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl[0], sda[1], busy[2], rx_byte[10:3], ack[11], zero
  output logic        out_tlast   // done_res
);

  i2cm_pkg::eng_state_t state_r, state_nxt;
  i2cm_pkg::tick_res_t  res_nxt;
  i2cm_pkg::tick_res_t  res_r;
  logic                 out_tvalid_r;
  logic                 in_accept;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  i2cm_step u_step (
    .state_i    (state_r),
    .req_type   (in_tuser),
    .tx_byte    (in_tdata[7:0]),
    .send_ack   (in_tdata[8]),
    .sda_sample (in_tdata[9]),
    .state_o    (state_nxt),
    .res_o      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= i2cm_pkg::STATE_RST;
      out_tvalid_r <= 1'b0;
    end else if (in_accept) begin
      state_r      <= state_nxt;
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, res_r.ack_status, res_r.rx_byte, res_r.busy_res,
                       res_r.sda_level, res_r.scl_level};
  assign out_tlast  = res_r.done_res;

endmodule

>>> hdl/i2cm_checker.sv
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic out_stall;

  assign out_stall = out_tvalid && !out_tready;

  // A stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable({out_tdata, out_tlast}))

  // An empty result register never blocks the input
  `CHK_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready)

  // Every accepted tick produces a result in the next cycle
  `CHK_ASSERT(a_tick_result, clk, rst_n, in_tvalid && in_tready |=> out_tvalid)

  // A finished command is always a busy tick
  `CHK_NEVER(a_done_busy, clk, rst_n, out_tvalid && out_tlast && !out_tdata[2])

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_i2cm_checker (.*);
